// ----- hw/rtl/bmpq_pkg.sv -----
`default_nettype none

package bmpq_pkg;

    // Fixed field widths of the item and result words
    localparam int BUCKET_IDX_W = 6;
    localparam int ELEM_ID_W    = 10;
    localparam int COUNT_W      = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Item kinds
    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_POP = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;    // clear one head entry
        logic load;        // capture the input word
        logic rd_bkt;      // read head of the item's bucket
        logic rd_hb;       // read head of the highest bucket
        logic scan_dec;    // step the mark down and read the next head
        logic hb_clear;    // mark: no bucket
        logic take_head;   // capture head id and read its link
        logic add_commit;  // push element, raise mark, count up
        logic pop_commit;  // unlink head, count down
        logic finish;      // load the result word
        logic res_err;     // result carries the pop error
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic is_add;
        logic add_ok;
        logic count_zero;
        logic hb_valid;
        logic head_zero;
        logic hb_zero;
    } t_status;

endpackage

`default_nettype wire

// ----- hw/rtl/bmpq_ram.sv -----
`default_nettype none

module bmpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bmpq_ctrl.sv -----
`default_nettype none

module bmpq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire bmpq_pkg::t_status i_sts,
    output bmpq_pkg::t_cmd         o_cmd,
    output logic                   o_busy,
    output logic                   o_done
);

    import bmpq_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_ADD    = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_LINK   = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_done;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_add) begin
                    if (i_sts.add_ok) begin
                        o_cmd.rd_bkt = 1'b1;
                        n_state      = S_ADD;
                    end else begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (i_sts.count_zero || !i_sts.hb_valid) begin
                    o_cmd.finish  = 1'b1;
                    o_cmd.res_err = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.rd_hb = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_ADD: begin
                o_cmd.add_commit = 1'b1;
                o_cmd.finish     = 1'b1;
                n_state          = S_IDLE;
            end
            S_SCAN: begin
                if (i_sts.head_zero) begin
                    if (i_sts.hb_zero) begin
                        o_cmd.hb_clear = 1'b1;
                        o_cmd.finish   = 1'b1;
                        o_cmd.res_err  = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.scan_dec = 1'b1;
                    end
                end else begin
                    o_cmd.take_head = 1'b1;
                    n_state         = S_LINK;
                end
            end
            S_LINK: begin
                o_cmd.pop_commit = 1'b1;
                o_cmd.finish     = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.finish;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

`default_nettype wire

// ----- hw/rtl/bmpq_dpath.sv -----
`default_nettype none

module bmpq_dpath #(
    parameter int NUM_BUCKETS  = 64,
    parameter int NUM_ELEMENTS = 1024
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire bmpq_pkg::t_cmd                       i_cmd,
    output bmpq_pkg::t_status                         o_sts,
    input  wire logic                                 i_kind,
    input  wire logic [bmpq_pkg::BUCKET_IDX_W-1:0]    i_bucket_index,
    input  wire logic [bmpq_pkg::ELEM_ID_W-1:0]       i_element_id,
    output logic      [bmpq_pkg::ELEM_ID_W-1:0]       o_popped_element,
    output logic                                      o_pop_error,
    output logic      [bmpq_pkg::COUNT_W-1:0]         o_element_count
);

    import bmpq_pkg::*;

    localparam int BW = $clog2(NUM_BUCKETS);
    localparam int EW = $clog2(NUM_ELEMENTS);
    localparam int HW = $clog2(NUM_ELEMENTS + 1);

    // Captured item
    logic          r_kind;
    logic          r_add_ok;
    logic [BW-1:0] r_bkt;
    logic [EW-1:0] r_elem;

    // Queue state
    logic [BW-1:0]      r_hb;
    logic               r_hb_valid;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [BW-1:0]      r_clr_addr;

    // Head being popped
    logic [HW-1:0] r_id;
    logic          r_id_ok;

    // Result word
    logic [ELEM_ID_W-1:0] r_res_pop;
    logic                 r_res_err;
    logic [COUNT_W-1:0]   r_res_count;

    logic          head_we, head_re;
    logic [BW-1:0] head_waddr, head_raddr;
    logic [HW-1:0] head_wdata, head_rdata;
    logic [HW-1:0] link_rdata, head_id, next_head;
    logic [BW-1:0] hb_m1;

    assign head_id   = head_rdata - HW'(1);
    assign hb_m1     = r_hb - BW'(1);
    assign next_head = r_id_ok ? link_rdata : '0;

    always_comb begin
        head_we    = 1'b0;
        head_waddr = r_bkt;
        head_wdata = '0;
        if (i_cmd.clr_step) begin
            head_we    = 1'b1;
            head_waddr = r_clr_addr;
        end else if (i_cmd.add_commit) begin
            head_we    = 1'b1;
            head_wdata = HW'(r_elem) + HW'(1);
        end else if (i_cmd.pop_commit) begin
            head_we    = 1'b1;
            head_waddr = r_hb;
            head_wdata = next_head;
        end
    end

    assign head_re    = i_cmd.rd_bkt | i_cmd.rd_hb | i_cmd.scan_dec;
    assign head_raddr = i_cmd.rd_bkt ? r_bkt : (i_cmd.scan_dec ? hb_m1 : r_hb);

    bmpq_ram #(
        .WIDTH (HW),
        .DEPTH (NUM_BUCKETS)
    ) u_heads (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_re    (head_re),
        .i_raddr (head_raddr),
        .o_rdata (head_rdata)
    );

    bmpq_ram #(
        .WIDTH (HW),
        .DEPTH (NUM_ELEMENTS)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add_commit),
        .i_waddr (r_elem),
        .i_wdata (head_rdata),
        .i_re    (i_cmd.take_head),
        .i_raddr (EW'(head_id)),
        .o_rdata (link_rdata)
    );

    always_comb begin
        n_count = r_count;
        if (i_cmd.add_commit && (r_count != COUNT_MAX)) begin
            n_count = r_count + COUNT_W'(1);
        end else if (i_cmd.pop_commit) begin
            n_count = r_count - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hb       <= '0;
            r_hb_valid <= 1'b0;
            r_count    <= '0;
            r_clr_addr <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + BW'(1);
            end
            if (i_cmd.add_commit && (!r_hb_valid || (r_bkt > r_hb))) begin
                r_hb       <= r_bkt;
                r_hb_valid <= 1'b1;
            end else if (i_cmd.scan_dec) begin
                r_hb <= hb_m1;
            end else if (i_cmd.hb_clear) begin
                r_hb_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_bkt    <= BW'(i_bucket_index);
            r_elem   <= EW'(i_element_id);
            r_add_ok <= (32'(i_bucket_index) < NUM_BUCKETS) &&
                        (32'(i_element_id) < NUM_ELEMENTS);
        end
        if (i_cmd.take_head) begin
            r_id    <= head_id;
            r_id_ok <= 32'(head_id) < NUM_ELEMENTS;
        end
        if (i_cmd.finish) begin
            r_res_pop   <= i_cmd.pop_commit ? ELEM_ID_W'(r_id) : '0;
            r_res_err   <= i_cmd.res_err;
            r_res_count <= n_count;
        end
    end

    assign o_sts.clr_last   = (r_clr_addr == BW'(NUM_BUCKETS - 1));
    assign o_sts.is_add     = (r_kind == KIND_ADD);
    assign o_sts.add_ok     = r_add_ok;
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.hb_valid   = r_hb_valid;
    assign o_sts.head_zero  = (head_rdata == '0);
    assign o_sts.hb_zero    = (r_hb == '0);

    assign o_popped_element = r_res_pop;
    assign o_pop_error      = r_res_err;
    assign o_element_count  = r_res_count;

endmodule

`default_nettype wire

// ----- hw/rtl/bucket_max_priority_queue_top.sv -----
// Bucket max-priority queue of element ids, one LIFO list per bucket. Issue a
// word with start while busy is low; the result word follows on o_done for
// exactly one cycle and cannot be held off, so capture it then. A pop steps the
// highest-bucket mark down past each empty bucket, each scan step being one
// read of the head table; a pop of an empty queue ends without a scan. After
// reset the head table is cleared one bucket a cycle, with busy held high.
`default_nettype none

module bucket_max_priority_queue_top #(
    parameter int NUM_BUCKETS  = 64,
    parameter int NUM_ELEMENTS = 1024
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_kind,
    input  wire logic [bmpq_pkg::BUCKET_IDX_W-1:0] i_bucket_index,
    input  wire logic [bmpq_pkg::ELEM_ID_W-1:0]    i_element_id,
    output logic                                   o_done,
    output logic      [bmpq_pkg::ELEM_ID_W-1:0]    o_popped_element,
    output logic                                   o_pop_error,
    output logic                                   o_queue_empty,
    output logic      [bmpq_pkg::COUNT_W-1:0]      o_element_count
);

    import bmpq_pkg::*;

    t_cmd    cmd;
    t_status sts;

    // Sequence each word: decode, table reads, commit
    bmpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // Hold the tables, mark, count and result word
    bmpq_dpath #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .NUM_ELEMENTS (NUM_ELEMENTS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_kind           (i_kind),
        .i_bucket_index   (i_bucket_index),
        .i_element_id     (i_element_id),
        .o_popped_element (o_popped_element),
        .o_pop_error      (o_pop_error),
        .o_element_count  (o_element_count)
    );

    assign o_queue_empty = (o_element_count == '0);

    // A result only ever ends a busy stretch
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a word in progress");

    // An accepted word keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("word accepted but block not busy");

    // An error result never carries an element
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_pop_error) |-> (o_popped_element == '0))
        else $error("pop error with nonzero element");

endmodule

`default_nettype wire

// ----- tb/bucket_queue_checker.sv -----
`timescale 1ns / 1ps

module bucket_queue_checker
    import bmpq_pkg::*;
#(
    parameter int NUM_BUCKETS  = 64,
    parameter int NUM_ELEMENTS = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  logic                    i_kind,
    input  logic [BUCKET_IDX_W-1:0] i_bucket_index,
    input  logic [ELEM_ID_W-1:0]    i_element_id,
    input  logic                    i_done,
    input  logic [ELEM_ID_W-1:0]    i_popped_element,
    input  logic                    i_pop_error,
    input  logic                    i_queue_empty,
    input  logic [COUNT_W-1:0]      i_element_count,
    output int                      o_fail_count,
    output int                      o_pending
);

    // Head and link entries hold an element id plus one; zero marks the end of a list.
    localparam int LINK_W = ELEM_ID_W + 1;

    typedef struct packed {
        logic [ELEM_ID_W-1:0] popped;
        logic                 err;
        logic                 empty;
        logic [COUNT_W-1:0]   count;
    } pq_result_t;

    logic [LINK_W-1:0]  head_tab [NUM_BUCKETS];
    logic [LINK_W-1:0]  link_tab [NUM_ELEMENTS];
    int                 top_bucket;
    logic [COUNT_W-1:0] queued;
    pq_result_t         expected_words[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Apply one word to the shadow queue and return the result it should produce.
    function automatic pq_result_t apply_word(input logic kind,
                                              input logic [BUCKET_IDX_W-1:0] bkt,
                                              input logic [ELEM_ID_W-1:0] elem);
        pq_result_t        r;
        logic [LINK_W-1:0] id;
        r = '0;
        if (kind == KIND_ADD) begin
            if (int'(bkt) < NUM_BUCKETS && int'(elem) < NUM_ELEMENTS) begin
                link_tab[elem] = head_tab[bkt];
                head_tab[bkt]  = LINK_W'(elem) + 1'b1;
                if (int'(bkt) > top_bucket)
                    top_bucket = int'(bkt);
                if (queued != COUNT_MAX)
                    queued = queued + 1'b1;
            end
        end else if (queued == '0) begin
            r.err = 1'b1;
        end else begin
            // scan down past empty buckets; a lost list can leave none at all
            while (top_bucket >= 0 && head_tab[top_bucket] == '0)
                top_bucket--;
            if (top_bucket < 0) begin
                r.err = 1'b1;
            end else begin
                id = head_tab[top_bucket] - 1'b1;
                head_tab[top_bucket] = (int'(id) < NUM_ELEMENTS) ? link_tab[id] : '0;
                queued   = queued - 1'b1;
                r.popped = id[ELEM_ID_W-1:0];
            end
        end
        r.empty = (queued == '0);
        r.count = queued;
        return r;
    endfunction

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        pq_result_t exp_word;
        if (!i_rst_n) begin
            foreach (head_tab[b]) head_tab[b] = '0;
            foreach (link_tab[e]) link_tab[e] = '0;
            top_bucket = -1;
            queued     = '0;
            expected_words.delete();
        end else begin
            // a result never belongs to the word accepted at the same edge
            if (i_done) begin
                if (expected_words.size() == 0) begin
                    $display("%0t ns: result word with none expected, actual %0d/%0d/%0d/%0d",
                             $time, i_popped_element, i_pop_error, i_queue_empty,
                             i_element_count);
                    o_fail_count++;
                end else begin
                    exp_word = expected_words.pop_front();
                    compare_field("popped_element", exp_word.popped, i_popped_element);
                    compare_field("pop_error", exp_word.err, i_pop_error);
                    compare_field("queue_empty", exp_word.empty, i_queue_empty);
                    compare_field("element_count", exp_word.count, i_element_count);
                end
            end
            if (i_start && !i_busy)
                expected_words.push_back(apply_word(i_kind, i_bucket_index, i_element_id));
        end
        o_pending = expected_words.size();
    end

endmodule

// ----- tb/bucket_max_priority_queue_top_test.sv -----
`timescale 1ns / 1ps

module bucket_max_priority_queue_top_test;
    import bmpq_pkg::*;

    localparam int NUM_BUCKETS  = 64;
    localparam int NUM_ELEMENTS = 1024;
    // cycles with no accepted word and no result before the run is declared hung
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 1500;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic                    i_kind;
    logic [BUCKET_IDX_W-1:0] i_bucket_index;
    logic [ELEM_ID_W-1:0]    i_element_id;
    logic                    o_done;
    logic [ELEM_ID_W-1:0]    o_popped_element;
    logic                    o_pop_error;
    logic                    o_queue_empty;
    logic [COUNT_W-1:0]      o_element_count;

    int fail_count;
    int pending;

    // Steering state for the stimulus, updated at accept and from what the block reports back.
    bit   queued_ids [NUM_ELEMENTS];
    int   count_seen;
    logic last_err;
    logic accepted_kind;
    int   idle_pct;
    int   stall_run;

    bucket_max_priority_queue_top #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .NUM_ELEMENTS (NUM_ELEMENTS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_bucket_index   (i_bucket_index),
        .i_element_id     (i_element_id),
        .o_done           (o_done),
        .o_popped_element (o_popped_element),
        .o_pop_error      (o_pop_error),
        .o_queue_empty    (o_queue_empty),
        .o_element_count  (o_element_count)
    );

    bucket_queue_checker #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .NUM_ELEMENTS (NUM_ELEMENTS)
    ) u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_kind           (i_kind),
        .i_bucket_index   (i_bucket_index),
        .i_element_id     (i_element_id),
        .i_done           (o_done),
        .i_popped_element (o_popped_element),
        .i_pop_error      (o_pop_error),
        .i_queue_empty    (o_queue_empty),
        .i_element_count  (o_element_count),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Track which ids sit in the queue so that the main random phase can avoid
    // pushing an id twice. Ids are marked at accept and cleared when the pop
    // that removes them reports back, so the map only ever errs on the safe side.
    always @(posedge i_clk) begin
        if (o_done) begin
            count_seen = o_element_count;
            last_err   = o_pop_error;
            if (accepted_kind == KIND_POP && !o_pop_error)
                queued_ids[o_popped_element] = 1'b0;
        end
        if (i_rst_n && start && !busy) begin
            accepted_kind = i_kind;
            if (i_kind == KIND_ADD)
                queued_ids[i_element_id] = 1'b1;
        end
    end

    // Watchdog: count cycles in which no word moves on either side. The clearing
    // pass after reset and the longest bucket scan are far below the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            stall_run = 0;
        else
            stall_run++;
        if (stall_run >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one word and hold it until the block takes it. Called at a falling
    // edge; returns at the falling edge after the accepting rising edge, with
    // start still high so a following word can go out without a gap.
    task automatic send_word(input logic kind, input logic [BUCKET_IDX_W-1:0] bkt,
                             input logic [ELEM_ID_W-1:0] elem);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start          <= 1'b1;
        i_kind         <= kind;
        i_bucket_index <= bkt;
        i_element_id   <= elem;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Pop with random junk on the ignored fields.
    task automatic send_pop();
        send_word(KIND_POP, BUCKET_IDX_W'($urandom), ELEM_ID_W'($urandom));
    endtask

    // Drop start, wait for every outstanding result, then return at a falling edge.
    task automatic wait_results();
        start <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int                    n;
        int                    tries;
        int                    add_pct;
        logic [BUCKET_IDX_W-1:0] hot_bucket;
        logic [BUCKET_IDX_W-1:0] bkt;
        logic [ELEM_ID_W-1:0]    elem;

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_kind         = KIND_ADD;
        i_bucket_index = '0;
        i_element_id   = '0;
        count_seen     = 0;
        last_err       = 1'b0;
        accepted_kind  = KIND_ADD;
        idle_pct       = 21;
        stall_run      = 0;
        add_pct        = 50;
        hot_bucket     = '0;

        // Hold reset, then release it on a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: pop of an empty queue, then field extremes and alternating
        // bit patterns, drained back to empty so the order of pops shows.
        send_pop();
        send_word(KIND_ADD, 6'd0,  10'd0);
        send_word(KIND_ADD, 6'd63, 10'd1023);
        send_word(KIND_ADD, 6'd63, 10'd512);
        send_word(KIND_ADD, 6'd0,  10'd1);
        send_word(KIND_ADD, 6'd21, 10'd341);
        send_word(KIND_ADD, 6'd42, 10'd682);
        repeat (6) send_pop();
        send_pop();
        send_word(KIND_ADD, 6'd0, 10'd7);
        send_pop();

        // Random: well-formed traffic with distinct ids. Alternate fill-heavy and
        // drain-heavy stretches so the queue swings between deep and empty, and
        // push half the adds into a few hot buckets to build long lists.
        for (n = 0; n < RANDOM_WORDS; n++) begin
            // drop idling over one long stretch so words go back to back
            idle_pct = (n >= 700 && n < 1100) ? 0 : 21;
            if (n % 150 == 0) begin
                add_pct    = ((n / 150) % 2 == 0) ? 75 : 25;
                hot_bucket = BUCKET_IDX_W'($urandom);
            end
            if ($urandom_range(0, 99) >= add_pct || count_seen > 400) begin
                send_pop();
            end else begin
                if ($urandom_range(0, 1) == 0)
                    bkt = BUCKET_IDX_W'($urandom);
                else
                    bkt = hot_bucket + BUCKET_IDX_W'($urandom_range(0, 2));
                elem  = ELEM_ID_W'($urandom);
                tries = 0;
                while (queued_ids[elem] && tries < 64) begin
                    elem = ELEM_ID_W'($urandom);
                    tries++;
                end
                send_word(KIND_ADD, bkt, elem);
            end
        end
        idle_pct = 21;

        // Drain until a pop reports an error, as a pop of an empty queue does.
        do begin
            send_pop();
            wait_results();
        end while (!last_err);

        // Directed: re-pushing a queued id into another bucket cuts the rest of
        // its old list loose, leaving a count with no bucket left to pop from.
        send_word(KIND_ADD, 6'd3, 10'd5);
        send_word(KIND_ADD, 6'd3, 10'd6);
        send_word(KIND_ADD, 6'd7, 10'd6);
        repeat (4) send_pop();

        // Random with repeated ids from a small pool, so lists cross and cycle.
        for (n = 0; n < 300; n++) begin
            if ($urandom_range(0, 99) < 40)
                send_pop();
            else
                send_word(KIND_ADD, BUCKET_IDX_W'($urandom),
                          ELEM_ID_W'($urandom_range(0, 15)));
        end

        // Lower start, collect the last results, and give a stray word time to show.
        start <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
